@@ hw/rtl/tfr_pkg.sv @@
// ----------------------------------------------------------------------------
// tfr_pkg
// Shared types and byte codes of the tagged frame receiver.
// ----------------------------------------------------------------------------
package tfr_pkg;

	typedef logic [7:0] byte_t;
	typedef logic signed [15:0] value_t;

	localparam byte_t HDR_BYTE = 8'hD8;
	localparam byte_t TRL_BYTE = 8'hEE;
	localparam byte_t TAG_BASE = 8'hB0;
	localparam int SLOT_COUNT = 4;

	// byte distance between the tags of neighboring slots; value bytes follow each tag
	localparam int SLOT_STRIDE = 3;

endpackage

@@ hw/rtl/tagged_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// tagged_frame_receiver
// Gathers fixed-length frames byte by byte and decodes four tagged slots.
// ----------------------------------------------------------------------------
// One byte is taken per cycle. Bytes run down a row of byte cells; when the
// last byte of a frame arrives, the frame body sits in the row and the four
// slots are decoded in that same cycle, so a result is ready in the cycle
// after the transfer of the trailer byte. A frame starts only on a 0xD8 byte;
// any other first byte is dropped. Each completed frame gives one result with
// frame_ok set when the trailer is 0xEE. Only the final byte of a frame can
// stall, and only while the previous result is still waiting to be taken.
module tagged_frame_receiver #(
	parameter int FRAME_LEN = 14
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            rx_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  frame_ok,
	output logic signed [15:0]    left_count,
	output logic signed [15:0]    right_count,
	output logic signed [15:0]    error_value,
	output logic signed [15:0]    control_value
);

	localparam int PosW = $clog2(FRAME_LEN);
	localparam int NumCells = FRAME_LEN - 2;
	localparam logic [PosW-1:0] LastPos = PosW'(FRAME_LEN - 1);

	logic [PosW-1:0] pos_q;
	logic            out_valid_q;
	logic            frame_ok_q;
	logic            last_byte;
	logic            take;
	logic            done;

	tfr_pkg::byte_t  chain [NumCells];
	tfr_pkg::value_t held  [tfr_pkg::SLOT_COUNT];

	assign last_byte = (pos_q == LastPos);
	assign in_ready  = !(last_byte && out_valid_q && !out_ready);
	assign take      = in_valid && in_ready;
	assign done      = take && last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (take) begin
			if (last_byte) begin
				pos_q <= '0;
			end else if ((pos_q == '0) && (rx_byte != tfr_pkg::HDR_BYTE)) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + PosW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			frame_ok_q  <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
			frame_ok_q  <= (rx_byte == tfr_pkg::TRL_BYTE);
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// newest byte in cell 0; frame position p sits in cell FRAME_LEN-2-p
	genvar gi;
	generate
		for (gi = 0; gi < NumCells; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				tfr_cell u_cell (
					.clk     (clk),
					.shift   (take),
					.byte_in (rx_byte),
					.byte_out(chain[gi])
				);
			end else begin : g_body
				tfr_cell u_cell (
					.clk     (clk),
					.shift   (take),
					.byte_in (chain[gi-1]),
					.byte_out(chain[gi])
				);
			end
		end

		for (gi = 0; gi < tfr_pkg::SLOT_COUNT; gi++) begin : g_slot
			localparam int TagPos = 1 + tfr_pkg::SLOT_STRIDE * gi;
			tfr_slot #(
				.SlotIdx(gi)
			) u_slot (
				.clk   (clk),
				.arst_n(arst_n),
				.update(done && (rx_byte == tfr_pkg::TRL_BYTE)),
				.tag   (chain[FRAME_LEN - 2 - TagPos]),
				.hi    (chain[FRAME_LEN - 3 - TagPos]),
				.lo    (chain[FRAME_LEN - 4 - TagPos]),
				.held  (held[gi])
			);
		end
	endgenerate

	assign out_valid     = out_valid_q;
	assign frame_ok      = frame_ok_q;
	assign left_count    = held[0];
	assign right_count   = held[1];
	assign error_value   = held[2];
	assign control_value = held[3];

endmodule

@@ hw/rtl/tfr_cell.sv @@
// ----------------------------------------------------------------------------
// tfr_cell
// One byte cell of the frame shift line; takes its neighbor's byte on shift.
// ----------------------------------------------------------------------------
module tfr_cell (
	input  logic           clk,
	input  logic           shift,
	input  tfr_pkg::byte_t byte_in,
	output tfr_pkg::byte_t byte_out
);

	tfr_pkg::byte_t data_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= byte_in;
		end
	end

	assign byte_out = data_q;

endmodule

@@ hw/rtl/tfr_slot.sv @@
// ----------------------------------------------------------------------------
// tfr_slot
// Tagged value slot: loads a big-endian 16-bit value when its tag matches.
// ----------------------------------------------------------------------------
module tfr_slot #(
	parameter int SlotIdx = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            update,
	input  tfr_pkg::byte_t  tag,
	input  tfr_pkg::byte_t  hi,
	input  tfr_pkg::byte_t  lo,
	output tfr_pkg::value_t held
);

	localparam tfr_pkg::byte_t SlotTag = tfr_pkg::byte_t'(tfr_pkg::TAG_BASE + SlotIdx);

	tfr_pkg::value_t held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (update && (tag == SlotTag)) begin
			held_q <= tfr_pkg::value_t'({hi, lo});
		end
	end

	assign held = held_q;

endmodule
